// ===== rtl/sklq_pkg.sv =====
// Shared types and constants for the sorted key list queue.
// Used by sklq_ctrl, sklq_datapath and sorted_key_list_queue; no dependencies.
package sklq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 32;
   localparam int PAY_W = 32;
   localparam int ACT_W = 3;
   localparam int ENTRY_COUNT_W = 5;
   localparam logic signed [KEY_W-1:0] LOW_KEY_RESET = 32'sd10000;

   typedef enum logic [ACT_W-1:0] {
      ACT_PREPEND      = 3'd0,
      ACT_APPEND       = 3'd1,
      ACT_REMOVE_FIRST = 3'd2,
      ACT_SORTED_INS   = 3'd3,
      ACT_REMOVE_KEY   = 3'd4
   } action_type;

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic signed [KEY_W-1:0] in_key;
      logic [PAY_W-1:0]        in_payload;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic signed [KEY_W-1:0] out_key;
      logic [PAY_W-1:0]        out_payload;
      logic                    refused;
      logic                    is_empty;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   // Operation chosen by the controller for the update cycle
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_FRONT,
      KIND_BACK,
      KIND_ORDER,
      KIND_POP,
      KIND_DROP,
      KIND_REFUSE
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic     load;
      logic     scan;
      logic     apply;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             empty;
      logic             full;
   } stat_type;

endpackage

// ===== rtl/sklq_ctrl.sv =====
// Controller for the sorted key list queue: sequences load, scan, apply and hold.
// Depends on sklq_pkg.
module sklq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  sklq_pkg::stat_type stat,
   output sklq_pkg::cmd_type  cmd
);

   sklq_pkg::state_type state_ff, state_in;
   sklq_pkg::kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sklq_pkg::ST_IDLE;
         kind_ff  <= sklq_pkg::KIND_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      cmd.scan  = 1'b0;
      cmd.apply = 1'b0;
      cmd.kind  = kind_ff;
      case (state_ff)
         sklq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sklq_pkg::ST_SCAN;
            end
         end
         sklq_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = sklq_pkg::ST_APPLY;
            case (stat.action)
               sklq_pkg::ACT_PREPEND:
                  kind_in = stat.full ? sklq_pkg::KIND_REFUSE : sklq_pkg::KIND_FRONT;
               sklq_pkg::ACT_APPEND:
                  kind_in = stat.full ? sklq_pkg::KIND_REFUSE : sklq_pkg::KIND_BACK;
               sklq_pkg::ACT_SORTED_INS:
                  kind_in = stat.full ? sklq_pkg::KIND_REFUSE : sklq_pkg::KIND_ORDER;
               sklq_pkg::ACT_REMOVE_FIRST:
                  kind_in = stat.empty ? sklq_pkg::KIND_NONE : sklq_pkg::KIND_POP;
               sklq_pkg::ACT_REMOVE_KEY:
                  kind_in = sklq_pkg::KIND_DROP;
               default:
                  kind_in = sklq_pkg::KIND_NONE;
            endcase
         end
         sklq_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = sklq_pkg::ST_HOLD;
         end
         sklq_pkg::ST_HOLD: begin
            rsp_valid = 1'b1;
            // take the next request as the result leaves
            if (!rsp_stall) begin
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = sklq_pkg::ST_SCAN;
               end else begin
                  state_in = sklq_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sklq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/sklq_datapath.sv =====
// Datapath for the sorted key list queue: request register, sorted cell row,
// count, key bounds and result register. Depends on sklq_pkg.
module sklq_datapath (
   input  logic               clock,
   input  logic               reset,
   input  sklq_pkg::req_type  req_data,
   input  sklq_pkg::cmd_type  cmd,
   output sklq_pkg::stat_type stat,
   output sklq_pkg::rsp_type  rsp_data
);

   localparam int N = sklq_pkg::DEPTH;
   localparam int CW = sklq_pkg::CNT_W;

   sklq_pkg::req_type              req_ff;
   logic signed [sklq_pkg::KEY_W-1:0] key_ff [N];
   logic signed [sklq_pkg::KEY_W-1:0] key_in [N];
   logic [sklq_pkg::PAY_W-1:0]     pay_ff [N];
   logic [sklq_pkg::PAY_W-1:0]     pay_in [N];
   logic [CW-1:0]                  count_ff, count_in;
   logic signed [sklq_pkg::KEY_W-1:0] low_ff, low_in, high_ff, high_in;
   logic [N-1:0]                   sh_ff, sh_in, rm_ff, rm_in;
   sklq_pkg::rsp_type              rsp_ff, rsp_in;

   logic [N-1:0] valid, open_slot, hit;
   logic [N-1:0] put_mask, take_mask, first_put, first_hit;
   logic signed [sklq_pkg::KEY_W-1:0] new_key, hit_key;
   logic [sklq_pkg::PAY_W-1:0]     hit_pay;
   logic                           empty, full;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(N));

   assign stat.action = req_ff.action;
   assign stat.empty  = empty;
   assign stat.full   = full;
   assign rsp_data    = rsp_ff;

   // Scan: per-cell compares, then prefix masks of where the row shifts
   always_comb begin
      for (int i = 0; i < N; i++) begin
         valid[i]     = (CW'(i) < count_ff);
         open_slot[i] = !valid[i] || (key_ff[i] > req_ff.in_key);
         hit[i]       = valid[i] && (key_ff[i] == req_ff.in_key);
      end
      for (int i = 0; i < N; i++) begin
         sh_in[i] = |(open_slot << (N - 1 - i));
         rm_in[i] = |(hit << (N - 1 - i));
      end
   end

   // Apply: shift cells up for a put, down for a take
   always_comb begin
      put_mask  = '0;
      take_mask = '0;
      new_key   = req_ff.in_key;
      case (cmd.kind)
         sklq_pkg::KIND_FRONT: begin
            put_mask = '1;
            new_key  = low_ff - sklq_pkg::KEY_W'(1);
         end
         sklq_pkg::KIND_BACK: begin
            put_mask = ~valid;
            new_key  = high_ff + sklq_pkg::KEY_W'(1);
         end
         sklq_pkg::KIND_ORDER: begin
            put_mask = sh_ff;
         end
         sklq_pkg::KIND_POP: begin
            take_mask = '1;
         end
         sklq_pkg::KIND_DROP: begin
            take_mask = rm_ff;
         end
         default: begin
            put_mask = '0;
         end
      endcase

      first_put = put_mask & ~(put_mask << 1);
      first_hit = rm_ff & ~(rm_ff << 1);

      hit_key = '0;
      hit_pay = '0;
      for (int i = 0; i < N; i++) begin
         if (first_hit[i]) begin
            hit_key = hit_key | key_ff[i];
            hit_pay = hit_pay | pay_ff[i];
         end
      end

      for (int i = 0; i < N; i++) begin
         key_in[i] = key_ff[i];
         pay_in[i] = pay_ff[i];
         if (first_put[i]) begin
            key_in[i] = new_key;
            pay_in[i] = req_ff.in_payload;
         end else if (put_mask[i]) begin
            key_in[i] = key_ff[(i + N - 1) % N];
            pay_in[i] = pay_ff[(i + N - 1) % N];
         end else if (take_mask[i] && (i < N - 1)) begin
            key_in[i] = key_ff[(i + 1) % N];
            pay_in[i] = pay_ff[(i + 1) % N];
         end
      end

      count_in = count_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      rsp_in   = '0;
      case (cmd.kind)
         sklq_pkg::KIND_FRONT: begin
            count_in = count_ff + 1'b1;
            low_in   = new_key;
            if (empty) begin
               high_in = new_key;
            end
         end
         sklq_pkg::KIND_BACK: begin
            count_in = count_ff + 1'b1;
            high_in  = new_key;
            if (empty) begin
               low_in = new_key;
            end
         end
         sklq_pkg::KIND_ORDER: begin
            count_in = count_ff + 1'b1;
            if (req_ff.in_key > high_ff) begin
               high_in = req_ff.in_key;
            end
            if (req_ff.in_key < low_ff) begin
               low_in = req_ff.in_key;
            end
         end
         sklq_pkg::KIND_POP: begin
            count_in           = count_ff - 1'b1;
            rsp_in.found       = 1'b1;
            rsp_in.out_key     = key_ff[0];
            rsp_in.out_payload = pay_ff[0];
         end
         sklq_pkg::KIND_DROP: begin
            if (|rm_ff) begin
               count_in           = count_ff - 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.out_key     = hit_key;
               rsp_in.out_payload = hit_pay;
            end
         end
         sklq_pkg::KIND_REFUSE: begin
            rsp_in.refused = 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.is_empty    = (count_in == '0);
      rsp_in.entry_count = sklq_pkg::ENTRY_COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         low_ff   <= sklq_pkg::LOW_KEY_RESET;
         high_ff  <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.scan) begin
         sh_ff <= sh_in;
         rm_ff <= rm_in;
      end
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < N; i++) begin
            key_ff[i] <= key_in[i];
            pay_ff[i] <= pay_in[i];
         end
      end
   end

endmodule

// ===== rtl/sorted_key_list_queue.sv =====
// Sorted key list queue: up to DEPTH (key, payload) entries in ascending key order.
// A request is taken into the request register, then a scan compares every cell
// with the key and an apply shifts the cell row and registers the result.
// A new request is not taken until the previous result has been taken;
// the next request is taken in the cycle its predecessor's result is taken.
// Reset clears count and bounds (low key 10000, high key 0).
module sorted_key_list_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sklq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sklq_pkg::rsp_type rsp_data
);

   sklq_pkg::cmd_type  cmd;
   sklq_pkg::stat_type stat;

   sklq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sklq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/sklq_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for sorted_key_list_queue: keeps its own copy of the sorted list,
// predicts the result of every accepted request and compares each result.
// Depends on sklq_pkg.
module sklq_list_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  sklq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  sklq_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);

   logic signed [sklq_pkg::KEY_W-1:0] key_row [sklq_pkg::DEPTH];
   logic [sklq_pkg::PAY_W-1:0]        tag_row [sklq_pkg::DEPTH];
   int                                held;
   logic signed [sklq_pkg::KEY_W-1:0] low_key;
   logic signed [sklq_pkg::KEY_W-1:0] high_key;
   sklq_pkg::rsp_type                 awaited_results [$];

   function automatic void shift_in(int pos, logic signed [sklq_pkg::KEY_W-1:0] key,
                                    logic [sklq_pkg::PAY_W-1:0] tag);
      int i;
      for (i = held; i > pos; i--) begin
         key_row[i] = key_row[i-1];
         tag_row[i] = tag_row[i-1];
      end
      key_row[pos] = key;
      tag_row[pos] = tag;
      held++;
   endfunction

   function automatic void shift_out(int pos);
      int i;
      for (i = pos; i + 1 < held; i++) begin
         key_row[i] = key_row[i+1];
         tag_row[i] = tag_row[i+1];
      end
      held--;
   endfunction

   function automatic sklq_pkg::rsp_type predict_list_op(sklq_pkg::req_type r);
      sklq_pkg::rsp_type res;
      int                pos;
      logic              was_empty;
      res = '0;
      was_empty = (held == 0);
      if ((r.action == sklq_pkg::ACT_PREPEND || r.action == sklq_pkg::ACT_APPEND ||
           r.action == sklq_pkg::ACT_SORTED_INS) && held >= sklq_pkg::DEPTH) begin
         res.refused = 1'b1;
      end else begin
         case (r.action)
            sklq_pkg::ACT_PREPEND: begin
               low_key = low_key - 1;
               if (was_empty) high_key = low_key;
               shift_in(0, low_key, r.in_payload);
            end
            sklq_pkg::ACT_APPEND: begin
               high_key = high_key + 1;
               if (was_empty) low_key = high_key;
               shift_in(held, high_key, r.in_payload);
            end
            sklq_pkg::ACT_REMOVE_FIRST: begin
               if (!was_empty) begin
                  res.found = 1'b1;
                  res.out_key = key_row[0];
                  res.out_payload = tag_row[0];
                  shift_out(0);
               end
            end
            sklq_pkg::ACT_SORTED_INS: begin
               // equal keys stay ahead of the new entry
               pos = 0;
               while (pos < held && key_row[pos] <= r.in_key) pos++;
               shift_in(pos, r.in_key, r.in_payload);
               if (r.in_key > high_key) high_key = r.in_key;
               if (r.in_key < low_key) low_key = r.in_key;
            end
            sklq_pkg::ACT_REMOVE_KEY: begin
               pos = 0;
               while (pos < held && key_row[pos] != r.in_key) pos++;
               if (pos < held) begin
                  res.found = 1'b1;
                  res.out_key = r.in_key;
                  res.out_payload = tag_row[pos];
                  shift_out(pos);
               end
            end
            default: begin
            end
         endcase
      end
      res.is_empty = (held == 0);
      res.entry_count = held[sklq_pkg::ENTRY_COUNT_W-1:0];
      return res;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      sklq_pkg::rsp_type want;
      if (reset) begin
         held = 0;
         low_key = sklq_pkg::LOW_KEY_RESET;
         high_key = '0;
         awaited_results.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) awaited_results.push_back(predict_list_op(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result with no request waiting, expected none, actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("found", want.found, rsp_data.found);
               check_field("out_key", want.out_key, rsp_data.out_key);
               check_field("out_payload", want.out_payload, rsp_data.out_payload);
               check_field("refused", want.refused, rsp_data.refused);
               check_field("is_empty", want.is_empty, rsp_data.is_empty);
               check_field("entry_count", want.entry_count, rsp_data.entry_count);
            end
         end
      end
      pending = awaited_results.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the sorted_key_list_queue testbench: clock, reset, request traffic,
// result stalls and the verdict. Depends on sklq_pkg, sklq_list_checker and the RTL.
module tb_top;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_START   = 1500;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [sklq_pkg::ACT_W-1:0] ACT_UNKNOWN_FIRST = 3'd5;
   localparam logic [sklq_pkg::ACT_W-1:0] ACT_UNKNOWN_LAST  = 3'd7;
   localparam logic signed [sklq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [sklq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_TOGGLE, STALL_HEAVY} stall_mode_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sklq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sklq_pkg::rsp_type rsp_data;
   int                fail_count;
   int                pending;
   int                cycles = 0;
   int                burst_left = 0;

   sorted_key_list_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sklq_list_checker list_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Result side: stall pattern is redrawn whenever its random span runs out, with one long hold
   initial begin : receiver
      stall_mode_type mode;
      int             span;
      int             tick;
      mode = STALL_NONE;
      span = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick == HOLD_START) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_HEAVY));
               span = $urandom_range(10, 80);
            end
            span--;
            case (mode)
               STALL_NONE:   rsp_stall = 1'b0;
               STALL_LIGHT:  rsp_stall = ($urandom_range(0, 99) < 30);
               STALL_TOGGLE: rsp_stall = tick[0];
               default:      rsp_stall = ($urandom_range(0, 99) < 70);
            endcase
         end
      end
   end

   function automatic logic signed [sklq_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 8) - 4;
         6: return 9985 + $urandom_range(0, 15);
         7: return $urandom_range(0, 20);
         default: return $urandom();
      endcase
   endfunction

   // Offer one request, hold it until taken, then either continue the burst or pause
   task automatic offer(input logic [sklq_pkg::ACT_W-1:0] act,
                        input logic signed [sklq_pkg::KEY_W-1:0] key,
                        input logic [sklq_pkg::PAY_W-1:0] tag);
      req_data = '{action: act, in_key: key, in_payload: tag};
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   initial begin : stimulus
      int                         count;
      int                         phase_left;
      int                         bias;
      int                         roll;
      logic [sklq_pkg::ACT_W-1:0] act;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list, first prepend and first append into an empty list
      offer(sklq_pkg::ACT_REMOVE_FIRST, '0, '0);
      offer(sklq_pkg::ACT_REMOVE_KEY, '1, '1);
      offer(sklq_pkg::ACT_PREPEND, '1, 32'hFFFF_FFFF);
      offer(sklq_pkg::ACT_REMOVE_FIRST, '0, '0);
      offer(sklq_pkg::ACT_APPEND, '0, '0);
      // equal keys: new entry goes behind, removal takes the frontmost
      offer(sklq_pkg::ACT_SORTED_INS, '0, 32'hFFFF_FFFF);
      offer(sklq_pkg::ACT_SORTED_INS, '0, $urandom());
      offer(sklq_pkg::ACT_REMOVE_KEY, '0, '0);
      // bounds at the key extremes, then wrap on append and prepend
      offer(sklq_pkg::ACT_SORTED_INS, KEY_MAX, $urandom());
      offer(sklq_pkg::ACT_APPEND, KEY_MIN, $urandom());
      offer(sklq_pkg::ACT_SORTED_INS, KEY_MIN, $urandom());
      offer(sklq_pkg::ACT_PREPEND, KEY_MAX, $urandom());
      offer(sklq_pkg::ACT_REMOVE_KEY, 12345, '0);
      offer(ACT_UNKNOWN_FIRST, KEY_MAX, 32'hFFFF_FFFF);
      offer(ACT_UNKNOWN_LAST, KEY_MIN, $urandom());
      // fill the list, then insert into a full list
      repeat (10) offer(sklq_pkg::ACT_SORTED_INS, pick_key(), $urandom());
      offer(sklq_pkg::ACT_PREPEND, '0, $urandom());
      offer(sklq_pkg::ACT_APPEND, '0, $urandom());
      offer(sklq_pkg::ACT_SORTED_INS, pick_key(), $urandom());

      count = 0;
      phase_left = 0;
      bias = 50;
      while (count < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0: bias = 85;
               1: bias = 50;
               default: bias = 15;
            endcase
            phase_left = $urandom_range(30, 90);
         end
         roll = $urandom_range(0, 99);
         if (roll < bias) begin
            case ($urandom_range(0, 3))
               0: act = sklq_pkg::ACT_PREPEND;
               1: act = sklq_pkg::ACT_APPEND;
               default: act = sklq_pkg::ACT_SORTED_INS;
            endcase
         end else if (roll < 97) begin
            act = $urandom_range(0, 1) ? sklq_pkg::ACT_REMOVE_FIRST : sklq_pkg::ACT_REMOVE_KEY;
         end else begin
            act = $urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST);
         end
         offer(act, pick_key(), $urandom());
         if (act <= sklq_pkg::ACT_REMOVE_KEY) begin
            count++;
            phase_left--;
         end
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
